// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-gated.
`define CHK_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, reset-gated.
`define CHK_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/fcu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcu_pkg
// Shared types and constants of the UART frame checker.
// ----------------------------------------------------------------------------
package fcu_pkg;

	localparam int MAX_FRAME = 16;
	localparam int MIN_FRAME = 4;
	localparam int IDX_W     = $clog2(MAX_FRAME);
	localparam int LEN_W     = $clog2(MAX_FRAME + 1);
	localparam int BANKS     = 2;
	localparam int BANK_W    = $clog2(BANKS);
	localparam int RAM_DEPTH = BANKS * MAX_FRAME;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd3;

	localparam logic [4:0] FRAME_LEN_RST    = 5'd13;
	localparam logic [7:0] TIMEOUT_MS_RST   = 8'd20;
	localparam logic [7:0] START_MARKER_RST = 8'h67;
	localparam logic [7:0] END_MARKER_RST   = 8'h73;
	localparam logic [7:0] CHK_FORCE        = 8'h80;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_TIMEOUT   = 3'd1;
	localparam logic [2:0] ERR_BAD_START = 3'd2;
	localparam logic [2:0] ERR_BAD_END   = 3'd3;
	localparam logic [2:0] ERR_CHECKSUM  = 3'd4;

	// One closed or dropped frame handed from front to back.
	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [LEN_W-1:0]  len;
		logic [2:0]        code;
	} desc_t;

	// Back end hands a buffer bank back to the front end.
	typedef struct packed {
		logic              valid;
		logic [BANK_W-1:0] bank;
	} rel_t;

endpackage

// File: rtl/fcu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/fcu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcu_front
// Input side: config registers, byte collection, timeout and frame checks.
// ----------------------------------------------------------------------------
module fcu_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  kind,
	input  logic [7:0]                            data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fcu_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [fcu_pkg::CFG_DAT_W-1:0]         cfg_data,
	output logic                                  q_push,
	output fcu_pkg::desc_t                        q_desc,
	input  logic                                  q_full,
	input  fcu_pkg::rel_t                         rel,
	output logic                                  ram_we,
	output logic [fcu_pkg::RAM_AW-1:0]            ram_waddr,
	output logic [7:0]                            ram_wdata
);
	import fcu_pkg::*;

	logic [4:0]        frame_len_q;
	logic [7:0]        timeout_q;
	logic [7:0]        start_q;
	logic [7:0]        end_q;
	logic [LEN_W-1:0]  count_q;
	logic [7:0]        sum_q;
	logic [7:0]        timer_q;
	logic [7:0]        first_q;
	logic [7:0]        chk_q;
	logic [BANK_W-1:0] wbank_q;
	logic [BANKS-1:0]  busy_q;

	logic [LEN_W-1:0]  len;
	logic              accept;
	logic              cfg_we;
	logic              len_we;
	logic              byte_in;
	logic              tick_in;
	logic [LEN_W-1:0]  count_nxt;
	logic              closing;
	logic              sum_en;
	logic              chk_en;
	logic [8:0]        timer_nxt;
	logic              timed_out;
	logic [2:0]        close_code;
	logic              good_close;
	logic [BANKS-1:0]  set_mask;
	logic [BANKS-1:0]  clr_mask;

	// Clamp the programmed length into the supported range.
	always_comb begin
		if (LEN_W'(frame_len_q) < LEN_W'(MIN_FRAME)) begin
			len = LEN_W'(MIN_FRAME);
		end else if (LEN_W'(frame_len_q) > LEN_W'(MAX_FRAME)) begin
			len = LEN_W'(MAX_FRAME);
		end else begin
			len = LEN_W'(frame_len_q);
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign len_we    = cfg_we && (cfg_index == REG_FRAME_LEN);

	assign full    = q_full || busy_q[wbank_q];
	assign accept  = push && !full;
	assign byte_in = accept && (kind == KIND_BYTE);
	assign tick_in = accept && (kind == KIND_TICK);

	assign count_nxt = count_q + LEN_W'(1);
	assign closing   = byte_in && (count_nxt == len);
	assign sum_en    = (count_q != '0) &&
		((LEN_W + 1)'(count_q) + (LEN_W + 1)'(3) <= (LEN_W + 1)'(len));
	assign chk_en    = (count_q == len - LEN_W'(2));

	assign timer_nxt = {1'b0, timer_q} + 9'd1;
	assign timed_out = tick_in && (count_q != '0) && (timer_nxt > {1'b0, timeout_q});

	always_comb begin
		if (first_q != start_q) begin
			close_code = ERR_BAD_START;
		end else if (data != end_q) begin
			close_code = ERR_BAD_END;
		end else if ((sum_q | CHK_FORCE) != chk_q) begin
			close_code = ERR_CHECKSUM;
		end else begin
			close_code = ERR_NONE;
		end
	end

	assign good_close = closing && (close_code == ERR_NONE);

	assign q_push      = closing || timed_out;
	assign q_desc.bank = wbank_q;
	assign q_desc.len  = len;
	assign q_desc.code = closing ? close_code : ERR_TIMEOUT;

	assign ram_we    = byte_in;
	assign ram_waddr = {wbank_q, count_q[IDX_W-1:0]};
	assign ram_wdata = data;

	always_comb begin
		set_mask = '0;
		clr_mask = '0;
		if (good_close) begin
			set_mask[wbank_q] = 1'b1;
		end
		if (rel.valid) begin
			clr_mask[rel.bank] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= FRAME_LEN_RST;
			timeout_q   <= TIMEOUT_MS_RST;
			start_q     <= START_MARKER_RST;
			end_q       <= END_MARKER_RST;
			count_q     <= '0;
			sum_q       <= '0;
			timer_q     <= '0;
			wbank_q     <= '0;
			busy_q      <= '0;
		end else begin
			busy_q <= (busy_q | set_mask) & ~clr_mask;
			if (good_close) begin
				wbank_q <= wbank_q + BANK_W'(1);
			end

			if (len_we || closing || timed_out) begin
				// drop or finish the partial frame
				count_q <= '0;
				sum_q   <= '0;
				timer_q <= '0;
			end else if (byte_in) begin
				count_q <= count_nxt;
				if (sum_en) begin
					sum_q <= sum_q + data;
				end
			end else if (tick_in && (count_q != '0)) begin
				timer_q <= timer_nxt[7:0];
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_LEN:    frame_len_q <= cfg_data[4:0];
					REG_TIMEOUT_MS:   timeout_q   <= cfg_data;
					REG_START_MARKER: start_q     <= cfg_data;
					REG_END_MARKER:   end_q       <= cfg_data;
					default:          ;
				endcase
			end
		end
	end

	// Header and checksum bytes kept for the close-time compare.
	always_ff @(posedge clk) begin
		if (byte_in && (count_q == '0)) begin
			first_q <= data;
		end
		if (byte_in && chk_en) begin
			chk_q <= data;
		end
	end

endmodule

// File: rtl/fcu_desc_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcu_desc_q
// Short FIFO of frame descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module fcu_desc_q (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  fcu_pkg::desc_t wr_desc,
	output logic           full,
	input  logic           rd,
	output fcu_pkg::desc_t rd_desc,
	output logic           valid
);
	import fcu_pkg::*;

	desc_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0]  wptr_q;
	logic [QPTR_W-1:0]  rptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign valid   = (cnt_q != '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && valid;
	assign rd_desc = ent_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wptr_q] <= wr_desc;
		end
	end

endmodule

// File: rtl/fcu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcu_back
// Output side: turns descriptors into result transactions; a good frame's bytes leave one per cycle while pop keeps up.
// ----------------------------------------------------------------------------
module fcu_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       desc_valid,
	input  fcu_pkg::desc_t             desc,
	output logic                       desc_pop,
	output logic                       ram_re,
	output logic [fcu_pkg::RAM_AW-1:0] ram_raddr,
	input  logic [7:0]                 ram_rdata,
	output fcu_pkg::rel_t              rel,
	output logic                       empty,
	input  logic                       pop,
	output logic [7:0]                 out_byte,
	output logic                       frame_ok,
	output logic [2:0]                 error_code,
	output logic                       last
);
	import fcu_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_LOAD
	} state_t;

	state_t            state_q;
	logic [BANK_W-1:0] bank_q;
	logic [LEN_W-1:0]  len_q;
	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [7:0]        byte_q;
	logic              ok_q;
	logic [2:0]        code_q;
	logic              last_q;

	logic              out_free;
	logic              is_err;
	logic              take_err;
	logic              take_good;
	logic              load_byte;
	logic              at_last;

	assign out_free  = !out_valid_q || pop;
	assign is_err    = (desc.code != ERR_NONE);
	assign take_err  = (state_q == ST_IDLE) && desc_valid && is_err && out_free;
	assign take_good = (state_q == ST_IDLE) && desc_valid && !is_err;
	assign desc_pop  = take_err || take_good;

	assign at_last   = (LEN_W'(idx_q) + LEN_W'(1) == len_q);
	assign load_byte = (state_q == ST_LOAD) && out_free;

	// Read byte 0 on take; prefetch the next as the current one moves to the output.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = {bank_q, idx_q + IDX_W'(1)};
		if (take_good) begin
			ram_re    = 1'b1;
			ram_raddr = {desc.bank, IDX_W'(0)};
		end else if (load_byte && !at_last) begin
			ram_re = 1'b1;
		end
	end

	assign rel.valid = load_byte && at_last;
	assign rel.bank  = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			bank_q      <= '0;
			len_q       <= '0;
			idx_q       <= '0;
			byte_q      <= '0;
			ok_q        <= 1'b0;
			code_q      <= ERR_NONE;
			last_q      <= 1'b0;
		end else begin
			if (take_err || load_byte) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take_err) begin
						byte_q      <= '0;
						ok_q        <= 1'b0;
						code_q      <= desc.code;
						last_q      <= 1'b1;
					end else if (take_good) begin
						bank_q  <= desc.bank;
						len_q   <= desc.len;
						idx_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (load_byte) begin
						byte_q      <= ram_rdata;
						ok_q        <= 1'b1;
						code_q      <= ERR_NONE;
						last_q      <= at_last;
						if (at_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty      = !out_valid_q;
	assign out_byte   = byte_q;
	assign frame_ok   = ok_q;
	assign error_code = code_q;
	assign last       = last_q;

endmodule

// File: rtl/uart_frame_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_frame_checker_unit
// Collects UART bytes into fixed-length frames, checks markers and checksum,
// and replays good frames byte by byte or reports one error per bad frame.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          kind, data
//  result    empty / pop          out_byte, frame_ok, error_code, last
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Each input transaction is taken by the front end while full is low.
//  A good frame leaves at one result per cycle while pop keeps up; an error
//  result leaves the cycle after its descriptor is taken.
//  full rises while the descriptor FIFO is full or the current frame buffer
//  bank still holds a frame not yet replayed; a stalled pop holds the back end.
//  Reset is asynchronous; the frame buffer is not cleared.
// ----------------------------------------------------------------------------
module uart_frame_checker_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          kind,
	input  logic [7:0]                    data,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    out_byte,
	output logic                          frame_ok,
	output logic [2:0]                    error_code,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fcu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fcu_pkg::CFG_DAT_W-1:0] cfg_data
);
	import fcu_pkg::*;

	logic              q_push;
	desc_t             q_wdesc;
	logic              q_full;
	logic              q_pop;
	desc_t             q_rdesc;
	logic              q_valid;
	rel_t              rel;
	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [RAM_AW-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	fcu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.data      (data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_push    (q_push),
		.q_desc    (q_wdesc),
		.q_full    (q_full),
		.rel       (rel),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	fcu_desc_q u_desc_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_desc (q_wdesc),
		.full    (q_full),
		.rd      (q_pop),
		.rd_desc (q_rdesc),
		.valid   (q_valid)
	);

	fcu_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fcu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (q_valid),
		.desc       (q_rdesc),
		.desc_pop   (q_pop),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.rel        (rel),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.frame_ok   (frame_ok),
		.error_code (error_code),
		.last       (last)
	);

endmodule

// File: rtl/fcu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcu_checker
// Port-level checks on the result channel of the frame checker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       frame_ok,
	input logic [2:0] error_code,
	input logic       last
);
	import fcu_pkg::*;

	// An error transaction is always the single, final result of its frame.
	`CHK_SAME(a_err_is_last, clk, arst_n, !empty && !frame_ok, last && (out_byte == 8'd0))

	// Error code is clear on frame bytes and set on error reports.
	`CHK_SAME(a_code_matches, clk, arst_n, !empty, frame_ok == (error_code == ERR_NONE))

	// Error codes stay within the defined set.
	`CHK_SAME(a_code_range, clk, arst_n, !empty, error_code <= ERR_CHECKSUM)

	// Hold the byte and last flag of a stalled result.
	`CHK_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_byte) && $stable(last))

endmodule

bind uart_frame_checker_unit fcu_checker u_fcu_checker (.*);
